// ===== hw/rtl/tlmc_pkg.sv =====
// Types, codes and constants shared by the traffic light mode controller.
package tlmc_pkg;

   // event kinds carried on req_tuser
   localparam logic [1:0] EV_SCAN  = 2'd0;
   localparam logic [1:0] EV_START = 2'd1;
   localparam logic [1:0] EV_COUNT = 2'd2;
   localparam logic [1:0] EV_FLASH = 2'd3;

   // lamp colors
   localparam logic [1:0] LAMP_OFF = 2'd0;
   localparam logic [1:0] LAMP_RED = 2'd1;
   localparam logic [1:0] LAMP_YEL = 2'd2;
   localparam logic [1:0] LAMP_GRN = 2'd3;

   // phases of the automatic run
   localparam logic [1:0] PH_NS_GRN = 2'd0;
   localparam logic [1:0] PH_NS_YEL = 2'd1;
   localparam logic [1:0] PH_EW_GRN = 2'd2;

   localparam int DUR_W = 7;
   localparam logic [DUR_W-1:0] DUR_MAX = 7'd99;
   localparam logic [DUR_W-1:0] DUR_MIN = 7'd1;
   localparam logic [1:0] STARTUP_TICKS = 2'd3;

   localparam int RSP_DATA_W = 48;

   typedef enum logic [7:0] {
      MODE_INIT = 8'b0000_0001,
      MODE_AUTO = 8'b0000_0010,
      MODE_EDR  = 8'b0000_0100,
      MODE_EDY  = 8'b0000_1000,
      MODE_EDG  = 8'b0001_0000,
      MODE_MAN  = 8'b0010_0000,
      MODE_FLY  = 8'b0100_0000,
      MODE_FLR  = 8'b1000_0000
   } mode_type;

   // output codes of the modes
   localparam logic [2:0] MC_INIT = 3'd0;
   localparam logic [2:0] MC_AUTO = 3'd1;
   localparam logic [2:0] MC_EDR  = 3'd2;
   localparam logic [2:0] MC_EDY  = 3'd3;
   localparam logic [2:0] MC_EDG  = 3'd4;
   localparam logic [2:0] MC_MAN  = 3'd5;
   localparam logic [2:0] MC_FLY  = 3'd6;
   localparam logic [2:0] MC_FLR  = 3'd7;

   typedef struct packed {
      logic down_press;
      logic up_press;
      logic select_press;
      logic mode_press;
   } press_type;

   typedef struct packed {
      mode_type         mode;
      logic [1:0]       phase;
      logic             manual_dir;
      logic [DUR_W-1:0] ns_count;
      logic [DUR_W-1:0] ew_count;
      logic [DUR_W-1:0] red_len;
      logic [DUR_W-1:0] yellow_len;
      logic [DUR_W-1:0] green_len;
      logic             balanced;
      logic [1:0]       startup_count;
      logic [1:0]       ns_lamp;
      logic [1:0]       ew_lamp;
   } state_type;

   localparam state_type STATE_RST = '{
      mode:          MODE_INIT,
      phase:         PH_NS_GRN,
      manual_dir:    1'b0,
      ns_count:      7'd0,
      ew_count:      7'd0,
      red_len:       7'd5,
      yellow_len:    7'd2,
      green_len:     7'd3,
      balanced:      1'b0,
      startup_count: 2'd0,
      ns_lamp:       LAMP_OFF,
      ew_lamp:       LAMP_OFF
   };

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] c;
      unique case (m)
         MODE_INIT: c = MC_INIT;
         MODE_AUTO: c = MC_AUTO;
         MODE_EDR:  c = MC_EDR;
         MODE_EDY:  c = MC_EDY;
         MODE_EDG:  c = MC_EDG;
         MODE_MAN:  c = MC_MAN;
         MODE_FLY:  c = MC_FLY;
         MODE_FLR:  c = MC_FLR;
         default:   c = MC_INIT;
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/traffic_light_mode_controller.sv =====
// Top level of the traffic light mode controller: input beat register, state, result register.
//
//  channel | dir | tdata                        | tuser
//  req_    | in  | 4 button presses (8 bits)    | event kind (2 bits)
//  rsp_    | out | mode, phase, lamps, counts,  | -
//          |     | durations, flags (48 bits)   |
//
// One event per cycle while rsp_tready is high: an accepted beat is held in the input
// register, and its result is written to the result register in the cycle the state updates.
// A req beat passes through the input register and then the result register to rsp_.
// A stalled result holds the result register; one more beat is held in the input register.
// Synchronous reset returns the controller to start-up mode with default durations.
module traffic_light_mode_controller import tlmc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] mode press, [1] select press, [2] up press, [3] down press, [7:4] zero
   input  logic [7:0]            req_tdata,
   // [1:0] req_type
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [2:0] mode_now, [4:3] phase_now, [6:5] ns_lamp, [8:7] ew_lamp,
   // [15:9] ns_remaining, [22:16] ew_remaining, [29:23] red_time,
   // [36:30] yellow_time, [43:37] green_time, [44] durations_ok,
   // [45] display_dirty, [47:46] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                  in_valid_ff;
   logic [1:0]            in_kind_ff;
   press_type             in_press_ff;
   state_type             state_ff;
   state_type             state_in;
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic [RSP_DATA_W-1:0] out_data_in;
   logic                  step_dirty;
   logic                  step_ok;
   logic                  advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff  <= req_tuser;
         in_press_ff <= press_type'(req_tdata[3:0]);
      end
   end

   tlmc_step u_step (
      .cur          (state_ff),
      .kind         (in_kind_ff),
      .press        (in_press_ff),
      .nxt          (state_in),
      .dirty        (step_dirty),
      .durations_ok (step_ok)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RST;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign out_data_in = {2'b00, step_dirty, step_ok,
                         state_in.green_len, state_in.yellow_len, state_in.red_len,
                         state_in.ew_count, state_in.ns_count,
                         state_in.ew_lamp, state_in.ns_lamp,
                         state_in.phase, mode_code(state_in.mode)};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // state moves only with a processed beat
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a processed beat");

   // input stage full and result stalled: no new beat may enter
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while both stages are blocked");

   a_dur_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.red_len >= DUR_MIN && state_ff.red_len <= DUR_MAX &&
       state_ff.yellow_len >= DUR_MIN && state_ff.yellow_len <= DUR_MAX &&
       state_ff.green_len >= DUR_MIN && state_ff.green_len <= DUR_MAX))
      else $error("duration out of range");

   // balanced automatic run always shows a lamp on both directions
   a_auto_lit: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == MODE_AUTO && state_ff.balanced) |->
      (state_ff.ns_lamp != LAMP_OFF && state_ff.ew_lamp != LAMP_OFF))
      else $error("dark lamp in balanced automatic run");

endmodule

// ===== hw/rtl/tlmc_step.sv =====
// Next-state logic: applies one event to the controller state.
module tlmc_step import tlmc_pkg::*; (
   input  state_type  cur,
   input  logic [1:0] kind,
   input  press_type  press,
   output state_type  nxt,
   output logic       dirty,
   output logic       durations_ok
);

   function automatic logic is_bal(input state_type s);
      logic [DUR_W:0] sum;
      sum = {1'b0, s.yellow_len} + {1'b0, s.green_len};
      return ({1'b0, s.red_len} == sum);
   endfunction

   function automatic state_type load_phase(input state_type s, input logic [1:0] ph);
      state_type r;
      r = s;
      r.phase = ph;
      case (ph)
         PH_NS_GRN: begin
            r.ns_count = s.green_len;  r.ew_count = s.red_len;
            r.ns_lamp = LAMP_GRN;      r.ew_lamp = LAMP_RED;
         end
         PH_NS_YEL: begin
            r.ns_count = s.yellow_len; r.ew_count = s.yellow_len;
            r.ns_lamp = LAMP_YEL;      r.ew_lamp = LAMP_RED;
         end
         PH_EW_GRN: begin
            r.ns_count = s.red_len;    r.ew_count = s.green_len;
            r.ns_lamp = LAMP_RED;      r.ew_lamp = LAMP_GRN;
         end
         default: begin
            r.ns_count = s.yellow_len; r.ew_count = s.yellow_len;
            r.ns_lamp = LAMP_RED;      r.ew_lamp = LAMP_YEL;
         end
      endcase
      return r;
   endfunction

   // enter auto; unbalanced keeps counts and phase, lamps go dark
   function automatic state_type enter_auto(input state_type s);
      state_type r;
      r = s;
      r.mode = MODE_AUTO;
      r.balanced = is_bal(s);
      if (r.balanced) begin
         r = load_phase(r, PH_NS_GRN);
      end else begin
         r.ns_lamp = LAMP_OFF;
         r.ew_lamp = LAMP_OFF;
      end
      return r;
   endfunction

   function automatic state_type enter_manual(input state_type s);
      state_type r;
      r = s;
      r.mode = MODE_MAN;
      r.manual_dir = 1'b0;
      r.ns_lamp = LAMP_RED;
      r.ew_lamp = LAMP_GRN;
      return r;
   endfunction

   function automatic logic [DUR_W-1:0] dur_up(input logic [DUR_W-1:0] v);
      return (v >= DUR_MAX) ? DUR_MIN : v + DUR_MIN;
   endfunction

   function automatic logic [DUR_W-1:0] dur_down(input logic [DUR_W-1:0] v);
      return (v <= DUR_MIN) ? DUR_MAX : v - DUR_MIN;
   endfunction

   function automatic logic [1:0] toggle(input logic [1:0] lamp, input logic [1:0] col);
      return (lamp == col) ? LAMP_OFF : col;
   endfunction

   state_type  st;
   logic       dt;
   logic       flash_en;
   logic [1:0] flash_col;

   always_comb begin
      st = cur;
      dt = 1'b0;
      flash_en = 1'b0;
      flash_col = LAMP_YEL;
      unique case (kind)
         EV_SCAN: begin
            // presses apply in order mode, select, up, down
            if (press.mode_press) begin
               if (st.mode == MODE_MAN || st.mode == MODE_FLY || st.mode == MODE_FLR) begin
                  st.manual_dir = 1'b0;
                  st.phase = PH_NS_GRN;
                  st = enter_auto(st);
                  if (!st.balanced) begin
                     st.ns_count = '0;
                     st.ew_count = '0;
                  end
               end else begin
                  st = enter_manual(st);
               end
               dt = 1'b1;
            end
            if (press.select_press) begin
               if (st.mode == MODE_AUTO) begin
                  st.mode = MODE_EDR;
                  st.ns_lamp = LAMP_OFF;
                  st.ew_lamp = LAMP_OFF;
                  dt = 1'b1;
               end else if (st.mode == MODE_EDR) begin
                  st.mode = MODE_EDY;
                  dt = 1'b1;
               end else if (st.mode == MODE_EDY) begin
                  st.mode = MODE_EDG;
                  dt = 1'b1;
               end else if (st.mode == MODE_EDG) begin
                  st = enter_auto(st);
                  dt = 1'b1;
               end else if (st.mode == MODE_MAN) begin
                  st.manual_dir = ~st.manual_dir;
                  st.ns_lamp = st.manual_dir ? LAMP_GRN : LAMP_RED;
                  st.ew_lamp = st.manual_dir ? LAMP_RED : LAMP_GRN;
                  dt = 1'b1;
               end
            end
            if (press.up_press) begin
               if (st.mode == MODE_EDR) begin
                  st.red_len = dur_up(st.red_len); dt = 1'b1;
               end else if (st.mode == MODE_EDY) begin
                  st.yellow_len = dur_up(st.yellow_len); dt = 1'b1;
               end else if (st.mode == MODE_EDG) begin
                  st.green_len = dur_up(st.green_len); dt = 1'b1;
               end else if (st.mode == MODE_MAN) begin
                  st.mode = MODE_FLY; dt = 1'b1;
               end else if (st.mode == MODE_FLY) begin
                  st = enter_manual(st); dt = 1'b1;
               end
            end
            if (press.down_press) begin
               if (st.mode == MODE_EDR) begin
                  st.red_len = dur_down(st.red_len); dt = 1'b1;
               end else if (st.mode == MODE_EDY) begin
                  st.yellow_len = dur_down(st.yellow_len); dt = 1'b1;
               end else if (st.mode == MODE_EDG) begin
                  st.green_len = dur_down(st.green_len); dt = 1'b1;
               end else if (st.mode == MODE_MAN) begin
                  st.mode = MODE_FLR; dt = 1'b1;
               end else if (st.mode == MODE_FLR) begin
                  st = enter_manual(st); dt = 1'b1;
               end
            end
         end
         EV_START: begin
            if (st.mode == MODE_INIT) begin
               if (st.startup_count >= STARTUP_TICKS) begin
                  st = enter_auto(st);
                  dt = 1'b1;
               end else begin
                  st.startup_count = st.startup_count + 2'd1;
               end
            end
         end
         EV_COUNT: begin
            if (st.mode == MODE_AUTO && st.balanced) begin
               if (st.ns_count != '0) st.ns_count = st.ns_count - 7'd1;
               if (st.ew_count != '0) st.ew_count = st.ew_count - 7'd1;
               if (st.ns_count == '0 || st.ew_count == '0) begin
                  st = load_phase(st, st.phase + 2'd1);
               end
               dt = 1'b1;
            end
         end
         EV_FLASH: begin
            if (st.mode == MODE_AUTO && !st.balanced) begin
               flash_en = 1'b1; flash_col = LAMP_YEL;
            end else if (st.mode == MODE_EDR || st.mode == MODE_FLR) begin
               flash_en = 1'b1; flash_col = LAMP_RED;
            end else if (st.mode == MODE_EDY || st.mode == MODE_FLY) begin
               flash_en = 1'b1; flash_col = LAMP_YEL;
            end else if (st.mode == MODE_EDG) begin
               flash_en = 1'b1; flash_col = LAMP_GRN;
            end
            if (flash_en) begin
               st.ns_lamp = toggle(st.ns_lamp, flash_col);
               st.ew_lamp = toggle(st.ew_lamp, flash_col);
            end
         end
      endcase
   end

   assign nxt          = st;
   assign dirty        = dt;
   assign durations_ok = is_bal(st);

endmodule
